// ===== hw/rtl/water_dipole_cosine_top_assert.svh =====
// Assertion macros for the water dipole cosine block.
`ifndef WATER_DIPOLE_COSINE_TOP_ASSERT_SVH
`define WATER_DIPOLE_COSINE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/wdc_pkg.sv =====
// Shared types and constants of the water dipole cosine block.
package wdc_pkg;

  localparam int IdxW     = 10;
  localparam int CosW     = 16;
  localparam int SumW     = 27;
  localparam int CntW     = 11;
  localparam int CountMax = 2047;
  localparam int ScaleW   = 15;
  localparam int NormW    = 32;
  localparam int DotW     = 34;
  localparam int ProdW    = 64;
  localparam int DivNumW  = 49;
  localparam int DivDenW  = 32;
  localparam int DivQW    = 17;

  localparam logic signed [CosW-1:0] CosOne    = 16'sh7fff;
  localparam logic signed [CosW-1:0] CosNegOne = 16'sh8000;

  localparam logic Cmd_Store   = 1'b0;
  localparam logic Cmd_Measure = 1'b1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_MOD   = 13'b0000000000010,
    S_RD    = 13'b0000000000100,
    S_SCALE = 13'b0000000001000,
    S_DOT   = 13'b0000000010000,
    S_MUL   = 13'b0000000100000,
    S_SQRT  = 13'b0000001000000,
    S_DIVS  = 13'b0000010000000,
    S_DIVW  = 13'b0000100000000,
    S_ACC   = 13'b0001000000000,
    S_MEAN  = 13'b0010000000000,
    S_MWAIT = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

endpackage

// ===== hw/rtl/water_dipole_cosine_top.sv =====
// Water dipole cosine block: reference store, cosine and frame mean.
//
// Input channel (in_valid/in_ready) takes one molecule request: command,
// index, oxygen and two hydrogen coordinates, and a last-in-frame mark.
// Output channel (out_valid/out_ready) gives one result per request.
// A store request writes the dipole (H1-O)+(H2-O) to the reference memory.
// A measure request reads that reference and gives the Q1.15 cosine; on the
// last item of a frame it also gives the frame mean with mean_valid set.
// One request is worked at a time; in_ready is high only while idle, so a
// new request waits for the idle state after the previous result is registered.
// A store repeats the index wrap subtract as needed, then ends. A measure
// with a zero-length vector goes straight to the frame sum; other measures
// pass the scaling shifter (one bit a cycle), the shared 15x15 multiplier,
// the square root and the shared divider; a frame end adds the mean divide.
// The next request is taken once the result sits in the output register,
// even while the receiver stalls; a stalled result holds its value.
// Reset clears the frame sum and count and empties the output register;
// reference memory is not cleared, so measure only stored molecules.
module water_dipole_cosine_top #(
  parameter int MAX_MOLECULES = 1024,
  parameter int COORD_BITS    = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic [wdc_pkg::IdxW-1:0]           molecule_index,
  input  logic signed [COORD_BITS-1:0]       oxygen_x,
  input  logic signed [COORD_BITS-1:0]       oxygen_y,
  input  logic signed [COORD_BITS-1:0]       oxygen_z,
  input  logic signed [COORD_BITS-1:0]       hydrogen1_x,
  input  logic signed [COORD_BITS-1:0]       hydrogen1_y,
  input  logic signed [COORD_BITS-1:0]       hydrogen1_z,
  input  logic signed [COORD_BITS-1:0]       hydrogen2_x,
  input  logic signed [COORD_BITS-1:0]       hydrogen2_y,
  input  logic signed [COORD_BITS-1:0]       hydrogen2_z,
  input  logic                               last_in_frame,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [wdc_pkg::CosW-1:0]    cosine,
  output logic [wdc_pkg::IdxW-1:0]           result_molecule,
  output logic signed [wdc_pkg::CosW-1:0]    frame_mean,
  output logic                               mean_valid
);

  localparam int W  = COORD_BITS + 2;
  localparam int AW = (MAX_MOLECULES > 1) ? $clog2(MAX_MOLECULES) : 1;

  wdc_pkg::state_t state;

  logic                          cmd_r, last_r;
  logic [wdc_pkg::IdxW-1:0]      idx_r, idx_mod;
  logic signed [W-1:0]           mu [3];
  logic [3*W-1:0]                mem [MAX_MOLECULES];
  logic [3*W-1:0]                rdata;
  logic [W-1:0]                  ma [3];
  logic [W-1:0]                  mb [3];
  logic [2:0]                    sa, sb;
  logic [3:0]                    step;
  logic [wdc_pkg::NormW-1:0]     na, nb;
  logic signed [wdc_pkg::DotW-1:0] dd;
  logic [wdc_pkg::ProdW-1:0]     sq_v, sq_r, sq_b;
  logic signed [wdc_pkg::CosW-1:0] cos_r, mean_r;
  logic                          mvalid_r;
  logic signed [wdc_pkg::SumW-1:0] sum;
  logic [wdc_pkg::CntW-1:0]      cnt;

  logic                          idx_wrap, wr_en, zero_vec, a_big, b_big;
  logic                          fin_take, div_wait;
  logic [AW-1:0]                 addr;
  logic signed [W-1:0]           ref_v [3];
  logic [wdc_pkg::ScaleW-1:0]    op1, op2;
  logic [2*wdc_pkg::ScaleW-1:0]  prod;
  logic [wdc_pkg::ProdW-1:0]     sq_trial;
  logic [wdc_pkg::DotW-1:0]      dmag;
  logic [wdc_pkg::SumW-1:0]      smag;
  logic                          div_start, div_done;
  logic [wdc_pkg::DivNumW-1:0]   div_num;
  logic [wdc_pkg::DivDenW-1:0]   div_den;
  logic [wdc_pkg::DivQW-1:0]     div_q;

  assign in_ready = (state == wdc_pkg::S_IDLE);
  assign idx_wrap = (32'(idx_mod) >= MAX_MOLECULES);
  assign addr     = AW'(idx_mod);
  assign wr_en    = (state == wdc_pkg::S_MOD) && !idx_wrap && (cmd_r == wdc_pkg::Cmd_Store);
  assign fin_take = (state == wdc_pkg::S_FIN) && (!out_valid || out_ready);
  assign div_wait = (state == wdc_pkg::S_DIVW) || (state == wdc_pkg::S_MWAIT);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ref_v[i] = rdata[i*W +: W];
    end
  end

  assign zero_vec = ((mu[0] | mu[1] | mu[2]) == '0) ||
                    ((ref_v[0] | ref_v[1] | ref_v[2]) == '0);
  assign a_big = ((ma[0] | ma[1] | ma[2]) >> wdc_pkg::ScaleW) != '0;
  assign b_big = ((mb[0] | mb[1] | mb[2]) >> wdc_pkg::ScaleW) != '0;

  // Operand select for the shared multiplier: |a|^2, |b|^2, then a.b
  always_comb begin
    case (step)
      4'd0:    begin op1 = ma[0][wdc_pkg::ScaleW-1:0]; op2 = ma[0][wdc_pkg::ScaleW-1:0]; end
      4'd1:    begin op1 = ma[1][wdc_pkg::ScaleW-1:0]; op2 = ma[1][wdc_pkg::ScaleW-1:0]; end
      4'd2:    begin op1 = ma[2][wdc_pkg::ScaleW-1:0]; op2 = ma[2][wdc_pkg::ScaleW-1:0]; end
      4'd3:    begin op1 = mb[0][wdc_pkg::ScaleW-1:0]; op2 = mb[0][wdc_pkg::ScaleW-1:0]; end
      4'd4:    begin op1 = mb[1][wdc_pkg::ScaleW-1:0]; op2 = mb[1][wdc_pkg::ScaleW-1:0]; end
      4'd5:    begin op1 = mb[2][wdc_pkg::ScaleW-1:0]; op2 = mb[2][wdc_pkg::ScaleW-1:0]; end
      4'd6:    begin op1 = ma[0][wdc_pkg::ScaleW-1:0]; op2 = mb[0][wdc_pkg::ScaleW-1:0]; end
      4'd7:    begin op1 = ma[1][wdc_pkg::ScaleW-1:0]; op2 = mb[1][wdc_pkg::ScaleW-1:0]; end
      default: begin op1 = ma[2][wdc_pkg::ScaleW-1:0]; op2 = mb[2][wdc_pkg::ScaleW-1:0]; end
    endcase
  end
  assign prod = op1 * op2;

  assign sq_trial = sq_r + sq_b;
  assign dmag     = dd[wdc_pkg::DotW-1] ? wdc_pkg::DotW'(-dd) : wdc_pkg::DotW'(dd);
  assign smag     = sum[wdc_pkg::SumW-1] ? wdc_pkg::SumW'(-sum) : wdc_pkg::SumW'(sum);

  assign div_start = ((state == wdc_pkg::S_DIVS) && (sq_r != '0)) ||
                     (state == wdc_pkg::S_MEAN);
  always_comb begin
    if (state == wdc_pkg::S_MEAN) begin
      div_num = wdc_pkg::DivNumW'(smag) + wdc_pkg::DivNumW'(cnt >> 1);
      div_den = wdc_pkg::DivDenW'(cnt);
    end else begin
      div_num = (wdc_pkg::DivNumW'(dmag) << 15) + wdc_pkg::DivNumW'(sq_r >> 1);
      div_den = sq_r[wdc_pkg::DivDenW-1:0];
    end
  end

  wdc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= {mu[2], mu[1], mu[0]};
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wdc_pkg::S_IDLE;
      out_valid <= 1'b0;
      sum       <= '0;
      cnt       <= '0;
    end else begin
      unique case (state)
        wdc_pkg::S_IDLE: begin
          if (in_valid) begin
            cmd_r    <= command;
            last_r   <= last_in_frame;
            idx_r    <= molecule_index;
            idx_mod  <= molecule_index;
            mu[0]    <= W'(hydrogen1_x) + W'(hydrogen2_x) - (W'(oxygen_x) <<< 1);
            mu[1]    <= W'(hydrogen1_y) + W'(hydrogen2_y) - (W'(oxygen_y) <<< 1);
            mu[2]    <= W'(hydrogen1_z) + W'(hydrogen2_z) - (W'(oxygen_z) <<< 1);
            cos_r    <= '0;
            mean_r   <= '0;
            mvalid_r <= 1'b0;
            state    <= wdc_pkg::S_MOD;
          end
        end
        wdc_pkg::S_MOD: begin
          if (idx_wrap) begin
            idx_mod <= idx_mod - wdc_pkg::IdxW'(MAX_MOLECULES);
          end else if (cmd_r == wdc_pkg::Cmd_Store) begin
            state <= wdc_pkg::S_FIN;
          end else begin
            state <= wdc_pkg::S_RD;
          end
        end
        wdc_pkg::S_RD: begin
          for (int i = 0; i < 3; i++) begin
            sa[i] <= mu[i][W-1];
            sb[i] <= ref_v[i][W-1];
            ma[i] <= mu[i][W-1] ? W'(-mu[i]) : W'(mu[i]);
            mb[i] <= ref_v[i][W-1] ? W'(-ref_v[i]) : W'(ref_v[i]);
          end
          if (zero_vec) begin
            cos_r <= wdc_pkg::CosOne;
            state <= wdc_pkg::S_ACC;
          end else begin
            state <= wdc_pkg::S_SCALE;
          end
        end
        wdc_pkg::S_SCALE: begin
          if (a_big) begin
            for (int i = 0; i < 3; i++) ma[i] <= ma[i] >> 1;
          end
          if (b_big) begin
            for (int i = 0; i < 3; i++) mb[i] <= mb[i] >> 1;
          end
          if (!a_big && !b_big) begin
            step  <= '0;
            na    <= '0;
            nb    <= '0;
            dd    <= '0;
            state <= wdc_pkg::S_DOT;
          end
        end
        wdc_pkg::S_DOT: begin
          case (step) inside
            [4'd0:4'd2]: na <= na + wdc_pkg::NormW'(prod);
            [4'd3:4'd5]: nb <= nb + wdc_pkg::NormW'(prod);
            4'd6: dd <= (sa[0] ^ sb[0]) ? dd - wdc_pkg::DotW'(prod) : dd + wdc_pkg::DotW'(prod);
            4'd7: dd <= (sa[1] ^ sb[1]) ? dd - wdc_pkg::DotW'(prod) : dd + wdc_pkg::DotW'(prod);
            default: dd <= (sa[2] ^ sb[2]) ? dd - wdc_pkg::DotW'(prod)
                                           : dd + wdc_pkg::DotW'(prod);
          endcase
          step <= step + 4'd1;
          if (step == 4'd8) state <= wdc_pkg::S_MUL;
        end
        wdc_pkg::S_MUL: begin
          sq_v  <= na * nb;
          sq_r  <= '0;
          sq_b  <= wdc_pkg::ProdW'(1) << (wdc_pkg::ProdW - 2);
          state <= wdc_pkg::S_SQRT;
        end
        wdc_pkg::S_SQRT: begin
          // Restoring square root, one result bit per cycle
          if (sq_v >= sq_trial) begin
            sq_v <= sq_v - sq_trial;
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          if (sq_b == wdc_pkg::ProdW'(1)) state <= wdc_pkg::S_DIVS;
        end
        wdc_pkg::S_DIVS: begin
          if (sq_r == '0) begin
            cos_r <= wdc_pkg::CosOne;
            state <= wdc_pkg::S_ACC;
          end else begin
            state <= wdc_pkg::S_DIVW;
          end
        end
        wdc_pkg::S_DIVW: begin
          if (div_done) begin
            if (dd[wdc_pkg::DotW-1]) begin
              cos_r <= (div_q >= wdc_pkg::DivQW'(32768)) ? wdc_pkg::CosNegOne
                                                         : -wdc_pkg::CosW'(div_q);
            end else begin
              cos_r <= (div_q >= wdc_pkg::DivQW'(32767)) ? wdc_pkg::CosOne
                                                         : wdc_pkg::CosW'(div_q);
            end
            state <= wdc_pkg::S_ACC;
          end
        end
        wdc_pkg::S_ACC: begin
          if (32'(cnt) < wdc_pkg::CountMax) begin
            sum <= sum + wdc_pkg::SumW'(cos_r);
            cnt <= cnt + wdc_pkg::CntW'(1);
          end
          state <= last_r ? wdc_pkg::S_MEAN : wdc_pkg::S_FIN;
        end
        wdc_pkg::S_MEAN: begin
          state <= wdc_pkg::S_MWAIT;
        end
        wdc_pkg::S_MWAIT: begin
          if (div_done) begin
            mean_r   <= sum[wdc_pkg::SumW-1] ? -wdc_pkg::CosW'(div_q) : wdc_pkg::CosW'(div_q);
            mvalid_r <= 1'b1;
            sum      <= '0;
            cnt      <= '0;
            state    <= wdc_pkg::S_FIN;
          end
        end
        wdc_pkg::S_FIN: begin
          if (!out_valid || out_ready) begin
            cosine          <= cos_r;
            result_molecule <= idx_r;
            frame_mean      <= mean_r;
            mean_valid      <= mvalid_r;
            state           <= wdc_pkg::S_IDLE;
          end
        end
        default: state <= wdc_pkg::S_IDLE;
      endcase
      if (fin_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `include "water_dipole_cosine_top_assert.svh"

  `WDC_ASSERT_IMP(a_cnt_bound, 1'b1, 32'(cnt) <= wdc_pkg::CountMax, "frame count overflow")
  `WDC_ASSERT_IMP(a_div_owner, div_done, div_wait, "divider result with no consumer")
  `WDC_ASSERT_NXT(a_fin_out, fin_take, out_valid && in_ready, "finished result not presented")

endmodule

// ===== hw/rtl/wdc_div.sv =====
// Shift-subtract divider, one quotient bit per cycle.
module wdc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [wdc_pkg::DivNumW-1:0]      num,
  input  logic [wdc_pkg::DivDenW-1:0]      den,
  output logic                             done,
  output logic [wdc_pkg::DivQW-1:0]        quot
);

  logic [wdc_pkg::DivNumW-1:0] rem;
  logic [wdc_pkg::DivNumW-1:0] dsh;
  logic [4:0]                  k;
  logic                        busy;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      rem  <= num;
      dsh  <= wdc_pkg::DivNumW'(den) << (wdc_pkg::DivQW - 1);
      quot <= '0;
      k    <= 5'(wdc_pkg::DivQW - 1);
      busy <= 1'b1;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[wdc_pkg::DivQW-2:0], 1'b1};
      end else begin
        quot <= {quot[wdc_pkg::DivQW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
      k   <= k - 5'd1;
      if (k == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the water dipole cosine block.
`timescale 1ns / 100ps

module tb_top;

  localparam int NumMol    = 1024;
  localparam int CoordMax  = 8388607;
  localparam int CoordMin  = -8388608;
  localparam int RandItems = 1000;
  localparam longint CycleLimit = 3000000;

  typedef struct {
    logic                           cmd;
    logic [wdc_pkg::IdxW-1:0]       idx;
    logic signed [23:0]             c[9];  // O xyz, H1 xyz, H2 xyz
    logic                           last;
  } molecule_t;

  typedef struct {
    logic signed [wdc_pkg::CosW-1:0] cos_val;
    logic [wdc_pkg::IdxW-1:0]        mol;
    logic signed [wdc_pkg::CosW-1:0] mean;
    logic                            mean_ok;
  } result_t;

  class molecule_scoreboard;
    longint ref_dip[NumMol][3];
    longint frame_sum;
    int     frame_count;
    result_t expected_q[$];
    int     errors;

    function new();
      frame_sum = 0;
      frame_count = 0;
      errors = 0;
    endfunction

    static function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
    endfunction

    static function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // shrink a dipole until every component fits in 15 bits of magnitude
    static function automatic void shrink(input longint v[3], output longint o[3]);
      longint mx;
      int s;
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) if (abs64(v[i]) > mx) mx = abs64(v[i]);
      while ((mx >> s) >= 32768) s++;
      for (int i = 0; i < 3; i++)
        o[i] = v[i] < 0 ? -(abs64(v[i]) >> s) : (abs64(v[i]) >> s);
    endfunction

    static function automatic longint dipole_cosine(longint a[3], longint b[3]);
      longint sa[3];
      longint sb[3];
      longint d;
      bit [63:0] na, nb, r, q;
      if ((a[0] | a[1] | a[2]) == 0 || (b[0] | b[1] | b[2]) == 0) return 32767;
      shrink(a, sa);
      shrink(b, sb);
      na = 0;
      nb = 0;
      d = 0;
      for (int i = 0; i < 3; i++) begin
        na += sa[i] * sa[i];
        nb += sb[i] * sb[i];
        d += sa[i] * sb[i];
      end
      r = int_sqrt(na * nb);
      if (r == 0) return 32767;
      q = (abs64(d) * 64'd32768 + r / 2) / r;
      if (d < 0) return q > 32768 ? -32768 : -longint'(q);
      return q > 32767 ? 32767 : longint'(q);
    endfunction

    function void note_request(molecule_t m);
      longint mu[3];
      longint cv;
      longint q;
      result_t e;
      for (int i = 0; i < 3; i++)
        mu[i] = (longint'(m.c[3+i]) - longint'(m.c[i])) +
                (longint'(m.c[6+i]) - longint'(m.c[i]));
      cv = 0;
      e.mean = '0;
      e.mean_ok = 1'b0;
      if (m.cmd == wdc_pkg::Cmd_Store) begin
        ref_dip[m.idx % NumMol] = mu;
      end else begin
        cv = dipole_cosine(mu, ref_dip[m.idx % NumMol]);
        if (frame_count < wdc_pkg::CountMax) begin
          frame_sum += cv;
          frame_count++;
        end
        if (m.last) begin
          q = (abs64(frame_sum) + frame_count / 2) / frame_count;
          e.mean = frame_sum < 0 ? -q : q;
          e.mean_ok = 1'b1;
          frame_sum = 0;
          frame_count = 0;
        end
      end
      e.cos_val = cv;
      e.mol = m.idx;
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: mol %0d cos %0d", $time,
                 got.mol, got.cos_val);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.cos_val !== e.cos_val) begin
        $display("%0t: cosine exp %0d got %0d", $time, e.cos_val, got.cos_val);
        errors++;
      end
      if (got.mol !== e.mol) begin
        $display("%0t: result_molecule exp %0d got %0d", $time, e.mol, got.mol);
        errors++;
      end
      if (got.mean !== e.mean) begin
        $display("%0t: frame_mean exp %0d got %0d", $time, e.mean, got.mean);
        errors++;
      end
      if (got.mean_ok !== e.mean_ok) begin
        $display("%0t: mean_valid exp %0b got %0b", $time, e.mean_ok, got.mean_ok);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic command, last_in_frame;
  logic [wdc_pkg::IdxW-1:0] molecule_index;
  logic signed [23:0] oxygen_x, oxygen_y, oxygen_z;
  logic signed [23:0] hydrogen1_x, hydrogen1_y, hydrogen1_z;
  logic signed [23:0] hydrogen2_x, hydrogen2_y, hydrogen2_z;
  logic signed [wdc_pkg::CosW-1:0] cosine, frame_mean;
  logic [wdc_pkg::IdxW-1:0] result_molecule;
  logic mean_valid;

  water_dipole_cosine_top i_dut (
    .clk, .rst, .in_valid, .in_ready, .command, .molecule_index,
    .oxygen_x, .oxygen_y, .oxygen_z, .hydrogen1_x, .hydrogen1_y, .hydrogen1_z,
    .hydrogen2_x, .hydrogen2_y, .hydrogen2_z, .last_in_frame,
    .out_valid, .out_ready, .cosine, .result_molecule, .frame_mean, .mean_valid
  );

  molecule_scoreboard sb = new();
  molecule_t  req_now;
  result_t    res_now;
  logic       in_hs, out_hs;
  bit         hold_req;
  bit         stored[NumMol];
  int         stored_ids[$];
  longint     cycles;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // snapshot both channels mid-cycle so the edge sees settled values
  always @(negedge clk) begin
    in_hs = in_valid && in_ready && !rst;
    out_hs = out_valid && out_ready && !rst;
    req_now.cmd = command;
    req_now.idx = molecule_index;
    req_now.c = '{oxygen_x, oxygen_y, oxygen_z, hydrogen1_x, hydrogen1_y,
                  hydrogen1_z, hydrogen2_x, hydrogen2_y, hydrogen2_z};
    req_now.last = last_in_frame;
    res_now = '{cosine, result_molecule, frame_mean, mean_valid};
  end

  always @(posedge clk) begin
    if (in_hs) sb.note_request(req_now);
    if (out_hs) sb.check_result(res_now);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    hold_req = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        for (n = 0; n < 600; n++) @(posedge clk);
        hold_req = 1'b0;
      end
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  end

  task automatic send_molecule(molecule_t m);
    int g;
    in_valid <= 1'b1;
    command <= m.cmd;
    molecule_index <= m.idx;
    {oxygen_x, oxygen_y, oxygen_z} <= {m.c[0], m.c[1], m.c[2]};
    {hydrogen1_x, hydrogen1_y, hydrogen1_z} <= {m.c[3], m.c[4], m.c[5]};
    {hydrogen2_x, hydrogen2_y, hydrogen2_z} <= {m.c[6], m.c[7], m.c[8]};
    last_in_frame <= m.last;
    do @(posedge clk); while (!in_hs);
    if (m.cmd == wdc_pkg::Cmd_Store && !stored[m.idx]) begin
      stored[m.idx] = 1'b1;
      stored_ids.insert(stored_ids.size(), m.idx);
    end
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic signed [23:0] pick_extreme();
    case ($urandom_range(2))
      0: return CoordMin;
      1: return CoordMax;
      default: return 0;
    endcase
  endfunction

  function automatic molecule_t make_molecule(logic cmd, int idx, logic last);
    molecule_t m;
    int off;
    m.cmd = cmd;
    m.idx = idx;
    m.last = last;
    case ($urandom_range(9)) inside
      [0:1]: for (int i = 0; i < 9; i++) m.c[i] = $urandom;
      2: for (int i = 0; i < 9; i++) m.c[i] = pick_extreme();
      3: begin  // hydrogens mirror each other: zero dipole
        for (int i = 0; i < 3; i++) begin
          off = $signed($urandom_range(65536)) - 32768;
          m.c[i] = $signed($urandom_range(4194304)) - 2097152;
          m.c[3+i] = m.c[i] + off;
          m.c[6+i] = m.c[i] - off;
        end
      end
      default: begin  // water-like geometry around a random oxygen
        for (int i = 0; i < 3; i++) begin
          m.c[i] = $signed($urandom_range(8388606)) - 4194303;
          m.c[3+i] = m.c[i] + $signed($urandom_range(13000)) - 6500;
          m.c[6+i] = m.c[i] + $signed($urandom_range(13000)) - 6500;
        end
      end
    endcase
    return m;
  endfunction

  function automatic molecule_t fixed_molecule(logic cmd, int idx, logic last,
                                               int o, int h1, int h2);
    molecule_t m;
    m.cmd = cmd;
    m.idx = idx;
    m.last = last;
    for (int i = 0; i < 3; i++) begin
      m.c[i] = o;
      m.c[3+i] = h1;
      m.c[6+i] = h2;
    end
    return m;
  endfunction

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    molecule_t m;
    logic cmd;
    int idx;
    cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    command = wdc_pkg::Cmd_Store;
    molecule_index = '0;
    {oxygen_x, oxygen_y, oxygen_z} = '0;
    {hydrogen1_x, hydrogen1_y, hydrogen1_z} = '0;
    {hydrogen2_x, hydrogen2_y, hydrogen2_z} = '0;
    last_in_frame = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero dipoles, opposite and orthogonal vectors
    send_molecule(fixed_molecule(wdc_pkg::Cmd_Store, 0, 1'b1, CoordMin, CoordMax, CoordMax));
    send_molecule(fixed_molecule(wdc_pkg::Cmd_Store, 1023, 1'b0, CoordMax, CoordMin,
                                 CoordMin));
    send_molecule(fixed_molecule(wdc_pkg::Cmd_Store, 5, 1'b0, 1234, 1234, 1234));
    m = fixed_molecule(wdc_pkg::Cmd_Store, 7, 1'b0, 0, 0, 0);
    m.c[3] = 65536;
    m.c[6] = 65536;
    send_molecule(m);
    send_molecule(fixed_molecule(wdc_pkg::Cmd_Measure, 0, 1'b0, CoordMin, CoordMax,
                                 CoordMax));
    send_molecule(fixed_molecule(wdc_pkg::Cmd_Measure, 0, 1'b0, CoordMax, CoordMin,
                                 CoordMin));
    send_molecule(fixed_molecule(wdc_pkg::Cmd_Measure, 1023, 1'b0, CoordMin, CoordMax,
                                 CoordMax));
    send_molecule(fixed_molecule(wdc_pkg::Cmd_Measure, 5, 1'b0, 0, 100, 300));
    send_molecule(fixed_molecule(wdc_pkg::Cmd_Measure, 0, 1'b0, 77, 77, 77));
    m = fixed_molecule(wdc_pkg::Cmd_Measure, 7, 1'b0, 0, 0, 0);
    m.c[4] = 65536;
    m.c[8] = 65536;
    send_molecule(m);
    send_molecule(fixed_molecule(wdc_pkg::Cmd_Measure, 1023, 1'b1, CoordMin, CoordMax,
                                 CoordMax));
    send_molecule(fixed_molecule(wdc_pkg::Cmd_Measure, 7, 1'b1, 0, 3, 3));
    send_molecule(fixed_molecule(wdc_pkg::Cmd_Measure, 0, 1'b1, CoordMax, CoordMin,
                                 CoordMin));

    for (int n = 0; n < RandItems; n++) begin
      if (n == 300) hold_req = 1'b1;
      if (n == 600) begin
        // stop offering while every outstanding result comes back
        in_valid <= 1'b0;
        drain();
      end
      cmd = (stored_ids.size() < 4 || $urandom_range(99) < 30) ? wdc_pkg::Cmd_Store
                                                                : wdc_pkg::Cmd_Measure;
      if (cmd == wdc_pkg::Cmd_Store) idx = $urandom_range(NumMol - 1);
      else idx = stored_ids[$urandom_range(stored_ids.size() - 1)];
      send_molecule(make_molecule(cmd, idx, $urandom_range(99) < 12));
    end

    in_valid <= 1'b0;
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/wdc_pkg.sv
hw/rtl/wdc_div.sv
hw/rtl/water_dipole_cosine_top.sv
verif/tb_top.sv
